// ===== src/dlefc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlefc_pkg - DLE/ETX frame checker shared definitions
// Framing symbols, phase encoding, defaults and result packing layout.
// ----------------------------------------------------------------------------
package dlefc_pkg;

   // framing symbols
   localparam logic [7:0] SYM_DLE = 8'h10;
   localparam logic [7:0] SYM_ETX = 8'h03;

   // default body limit, in unstuffed bytes
   localparam int MAX_BODY_DEFAULT = 256;

   // result tdata layout, lowest bit up
   localparam int RSP_DATA_LSB  = 0;
   localparam int RSP_ID_LSB    = 8;
   localparam int RSP_INDEX_LSB = 16;
   localparam int RSP_COK_BIT   = 24;
   localparam int RSP_LOK_BIT   = 25;
   localparam int RSP_SUM_LSB   = 26;
   localparam int RSP_USED_W    = 34;
   localparam int RSP_TDATA_W   = 40;

   // result kinds carried on tuser
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // receive phase
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_ID   = 2'd1,
      PH_LEN  = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

endpackage

// ===== src/dle_etx_frame_checker.sv =====
// ----------------------------------------------------------------------------
// dle_etx_frame_checker - DLE/ETX stuffed frame deframer and checksum check
// Hunts for DLE, takes id and length, unstuffs the body, emits payload bytes
// and a status transfer with checksum and length verdicts at DLE ETX.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one raw received byte per transfer (req_tdata[7:0]).
//  - rsp_* carries zero or one result per input byte: a payload byte
//    (rsp_tuser = 0) or an end-of-frame status (rsp_tuser = 1, rsp_tlast = 1).
//  - a result is registered: it appears on rsp_* in the cycle after the byte
//    that causes it is accepted.
//  - throughput: one byte per cycle while no result is held or it is taken;
//    the frame state update is an 8-bit add, a count increment and compares
//    between the phase registers and the result register.
//  - the result register frees itself in the same cycle it is taken, so
//    req_tready stays high while rsp_tready is high or no result is held.
//  - when the receiver stalls with a result held, req_tready drops until
//    that result is taken; nothing is lost or repeated.
//  - reset (synchronous, active high) returns to hunting for a start DLE
//    and empties the result register.
//  - a frame broken by a DLE + other byte, or one whose body overruns
//    MAX_BODY bytes, is dropped without a status transfer.
// ----------------------------------------------------------------------------
module dle_etx_frame_checker
   import dlefc_pkg::*;
#(
   parameter int MAX_BODY = MAX_BODY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] data, [15:8] packet_id, [23:16] byte_index, [24] checksum_ok,
   // [25] length_ok, [33:26] computed_sum, [39:34] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,   // [0] kind
   output logic                   rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_BODY + 1);

   // frame state
   phase_type        phase_ff, phase_in;
   logic             dle_seen_ff, dle_seen_in;
   logic [7:0]       frame_id_ff, frame_id_in;
   logic [7:0]       frame_length_ff, frame_length_in;
   logic [CNT_W-1:0] body_count_ff, body_count_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [7:0]       received_check_ff, received_check_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic       req_xfer;
   logic [7:0] rx_byte;
   logic [8:0] count_ext;
   logic [8:0] length_ext;
   logic       body_full;
   logic       in_payload;
   logic       at_check;
   logic       is_body_byte;
   logic       is_etx_end;
   logic       res_valid;
   logic       res_kind;
   logic [7:0] res_data;
   logic [7:0] res_index;
   logic       res_cok;
   logic       res_lok;
   logic [7:0] res_sum;

   assign req_xfer   = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // body position compares
   assign count_ext  = 9'(body_count_ff);
   assign length_ext = {1'b0, frame_length_ff};
   assign body_full  = count_ext >= 9'(MAX_BODY);
   assign in_payload = count_ext < length_ext;
   assign at_check   = count_ext == length_ext;

   // an unstuffed body byte: plain non-DLE, or the second of a doubled DLE
   assign is_body_byte = (phase_ff == PH_BODY) &&
                         ((!dle_seen_ff && rx_byte != SYM_DLE) ||
                          (dle_seen_ff && rx_byte == SYM_DLE));
   assign is_etx_end   = (phase_ff == PH_BODY) && dle_seen_ff && rx_byte == SYM_ETX;

   // next frame state
   always_comb begin
      phase_in          = phase_ff;
      dle_seen_in       = dle_seen_ff;
      frame_id_in       = frame_id_ff;
      frame_length_in   = frame_length_ff;
      body_count_in     = body_count_ff;
      running_sum_in    = running_sum_ff;
      received_check_in = received_check_ff;
      case (phase_ff)
         PH_ID: begin
            if (rx_byte == SYM_ETX) begin
               phase_in = PH_HUNT;
            end else begin
               frame_id_in       = rx_byte;
               running_sum_in    = rx_byte;
               frame_length_in   = 8'd0;
               body_count_in     = '0;
               received_check_in = 8'd0;
               dle_seen_in       = 1'b0;
               phase_in          = PH_LEN;
            end
         end
         PH_LEN: begin
            frame_length_in = rx_byte;
            running_sum_in  = running_sum_ff + rx_byte;
            body_count_in   = '0;
            dle_seen_in     = 1'b0;
            phase_in        = PH_BODY;
         end
         PH_BODY: begin
            if (!dle_seen_ff && rx_byte == SYM_DLE) begin
               dle_seen_in = 1'b1;
            end else if (is_body_byte) begin
               dle_seen_in = 1'b0;
               if (body_full) begin
                  phase_in = PH_HUNT;
               end else begin
                  if (in_payload) begin
                     running_sum_in = running_sum_ff + rx_byte;
                  end else if (at_check) begin
                     received_check_in = rx_byte;
                  end
                  body_count_in = body_count_ff + 1'b1;
               end
            end else if (is_etx_end) begin
               dle_seen_in = 1'b0;
               phase_in    = PH_HUNT;
            end else begin
               // DLE + other byte: restart with this byte as the id
               frame_id_in       = rx_byte;
               running_sum_in    = rx_byte;
               frame_length_in   = 8'd0;
               body_count_in     = '0;
               received_check_in = 8'd0;
               dle_seen_in       = 1'b0;
               phase_in          = PH_LEN;
            end
         end
         default: begin
            dle_seen_in = 1'b0;
            phase_in    = (rx_byte == SYM_DLE) ? PH_ID : PH_HUNT;
         end
      endcase
   end

   // result generation
   always_comb begin
      res_valid = 1'b0;
      res_kind  = KIND_PAYLOAD;
      res_data  = 8'd0;
      res_index = 8'd0;
      res_cok   = 1'b0;
      res_lok   = 1'b0;
      res_sum   = 8'd0;
      if (is_body_byte && !body_full && in_payload) begin
         res_valid = 1'b1;
         res_data  = rx_byte;
         res_index = count_ext[7:0];
      end else if (is_etx_end) begin
         res_valid = 1'b1;
         res_kind  = KIND_STATUS;
         res_sum   = 8'd0 - running_sum_ff;
         res_cok   = (count_ext > length_ext) && (res_sum == received_check_ff);
         res_lok   = count_ext == (length_ext + 9'd1);
      end
   end

   // result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_xfer) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, res_sum, res_lok, res_cok,
                           res_index, frame_id_in, res_data};
            rsp_kind_in = res_kind;
            rsp_last_in = res_kind == KIND_STATUS;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         dle_seen_ff       <= 1'b0;
         frame_id_ff       <= 8'd0;
         frame_length_ff   <= 8'd0;
         body_count_ff     <= '0;
         running_sum_ff    <= 8'd0;
         received_check_ff <= 8'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff          <= phase_in;
            dle_seen_ff       <= dle_seen_in;
            frame_id_ff       <= frame_id_in;
            frame_length_ff   <= frame_length_in;
            body_count_ff     <= body_count_in;
            running_sum_ff    <= running_sum_in;
            received_check_ff <= received_check_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // length byte always opens the body
   a_len_to_body: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && phase_ff == PH_LEN) |=> (phase_ff == PH_BODY))
      else $error("length byte did not move to body phase");

   // body count never passes the body limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (9'(body_count_ff) <= 9'(MAX_BODY)))
      else $error("body count beyond limit");

   // pending DLE only exists inside a body
   a_dle_in_body: assert property (@(posedge clock) disable iff (reset)
      dle_seen_ff |-> (phase_ff == PH_BODY))
      else $error("pending DLE outside body phase");

   // DLE ETX in a body gives a status transfer and resumes hunting
   a_etx_status: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_etx_end) |=>
         (rsp_tvalid && rsp_tlast && rsp_tuser == KIND_STATUS && phase_ff == PH_HUNT))
      else $error("frame end without status transfer");

endmodule
